/* rtl/core/rhsv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, hue constants and pipeline types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 15;

   // hue scale: 64 units per degree
   localparam int HUE_Q_BITS       = 12;   // quotient of 3840*|diff|/delta fits 0..3840
   localparam int HUE_SIXTH_SHIFT  = 12;   // 3840 = 2^12 - 2^8
   localparam int HUE_SIXTH_SUB    = 8;
   localparam int DIV_STAGES       = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
   localparam int REM_BITS         = CHANNEL_BITS + DIV_STAGES;
   // front stage, numerator stage, divider stages, output stage
   localparam int NUM_STAGES       = DIV_STAGES + 3;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0]     hue_type;
   typedef logic [REM_BITS-1:0]     rem_type;
   typedef logic [DIV_STAGES-1:0]   quo_type;

   localparam hue_type HUE_BASE_RED   = HUE_BITS'(0);
   localparam hue_type HUE_BASE_GREEN = HUE_BITS'(7680);
   localparam hue_type HUE_BASE_BLUE  = HUE_BITS'(15360);
   localparam hue_type HUE_FULL       = HUE_BITS'(23040);

   typedef enum logic [2:0] {
      SECT_RED   = 3'b001,
      SECT_GREEN = 3'b010,
      SECT_BLUE  = 3'b100
   } sector_type;

   typedef struct packed {
      chan_type   red;
      chan_type   green;
      chan_type   blue;
      chan_type   top;
      chan_type   bottom;
      sector_type sector;
   } front_type;

   typedef struct packed {
      rem_type    sat_rem;
      rem_type    hue_rem;
      quo_type    sat_quo;
      quo_type    hue_quo;
      chan_type   top;
      chan_type   delta;
      sector_type sector;
      logic       neg;
      logic       undef;
   } div_type;

endpackage
`default_nettype wire

/* rtl/core/rhsv_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_if
// Valid/ready channels carrying RGB requests and HSV responses.
// ----------------------------------------------------------------------------
interface rhsv_req_if;
   import rhsv_pkg::*;

   logic     valid;
   logic     ready;
   chan_type red_in;
   chan_type green_in;
   chan_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface rhsv_rsp_if;
   import rhsv_pkg::*;

   logic     valid;
   logic     ready;
   hue_type  hue_out;
   chan_type saturation_out;
   chan_type value_out;
   logic     hue_undefined;

   modport source (output valid, output hue_out, output saturation_out,
                   output value_out, output hue_undefined, input ready);
   modport sink   (input valid, input hue_out, input saturation_out,
                   input value_out, input hue_undefined, output ready);
endinterface
`default_nettype wire

/* rtl/core/rgb_to_hsv_pixel_converter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_top
// Pipelined RGB to HSV conversion, one pixel per clock unless the response stalls.
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  req_chan   in   valid / ready      red_in, green_in, blue_in
//  rsp_chan   out  valid / ready      hue_out, saturation_out, value_out,
//                                     hue_undefined
//
//  Pipeline: max/min stage, numerator stage, one restoring divide step per
//  stage, output register. One pixel per clock while responses are taken;
//  both divides run side by side per stage.
//  Synchronous reset clears only the stage valid bits.
//  Each stage holds while its successor is full and stalled; empty stages
//  keep filling, so requests are taken while a response waits.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_converter_top (
   input  wire        clock,
   input  wire        reset,
   rhsv_req_if.sink   req_chan,
   rhsv_rsp_if.source rsp_chan
);
   import rhsv_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES:0]   ld;

   front_type front_ff;
   front_type front_in;
   div_type   div_ff [DIV_STAGES+1];
   div_type   div_in [DIV_STAGES+1];

   hue_type  hue_ff,   hue_in;
   chan_type sat_ff,   sat_in;
   chan_type value_ff;
   logic     undef_ff;

   // stage load enables, back to front
   always_comb begin
      ld[NUM_STAGES] = rsp_chan.ready;
      for (int s = LAST; s >= 0; s--) begin
         ld[s] = !vld_ff[s] || ld[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (ld[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // ---- stage 0: max, min, dominant channel (red wins ties, then green)
   always_comb begin
      chan_type r, g, b;
      r = req_chan.red_in;
      g = req_chan.green_in;
      b = req_chan.blue_in;
      front_in.red   = r;
      front_in.green = g;
      front_in.blue  = b;
      priority if (r >= g && r >= b) begin
         front_in.top    = r;
         front_in.sector = SECT_RED;
      end else if (g >= b) begin
         front_in.top    = g;
         front_in.sector = SECT_GREEN;
      end else begin
         front_in.top    = b;
         front_in.sector = SECT_BLUE;
      end
      priority if (r <= g && r <= b) begin
         front_in.bottom = r;
      end else if (g <= b) begin
         front_in.bottom = g;
      end else begin
         front_in.bottom = b;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         front_ff <= front_in;
      end
   end

   // ---- stage 1: delta, |diff| and both dividends
   always_comb begin
      chan_type a, b, delta, adiff;
      logic     neg;
      unique case (front_ff.sector)
         SECT_RED: begin
            a = front_ff.green;
            b = front_ff.blue;
         end
         SECT_GREEN: begin
            a = front_ff.blue;
            b = front_ff.red;
         end
         SECT_BLUE: begin
            a = front_ff.red;
            b = front_ff.green;
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      delta = front_ff.top - front_ff.bottom;
      neg   = (a < b);
      adiff = neg ? (b - a) : (a - b);

      div_in[0].sat_rem = (REM_BITS'(delta) << CHANNEL_BITS) - REM_BITS'(delta);
      div_in[0].hue_rem = (REM_BITS'(adiff) << HUE_SIXTH_SHIFT)
                        - (REM_BITS'(adiff) << HUE_SIXTH_SUB);
      div_in[0].sat_quo = '0;
      div_in[0].hue_quo = '0;
      div_in[0].top     = front_ff.top;
      div_in[0].delta   = delta;
      div_in[0].sector  = front_ff.sector;
      div_in[0].neg     = neg;
      div_in[0].undef   = (delta == '0);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ---- restoring divide, one quotient bit of each divide per stage
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      localparam int QBIT = DIV_STAGES - 1 - i;

      always_comb begin
         rem_type sat_dvs, hue_dvs;
         sat_dvs    = REM_BITS'(div_ff[i].top)   << QBIT;
         hue_dvs    = REM_BITS'(div_ff[i].delta) << QBIT;
         div_in[i+1] = div_ff[i];
         if (div_ff[i].sat_rem >= sat_dvs) begin
            div_in[i+1].sat_rem       = div_ff[i].sat_rem - sat_dvs;
            div_in[i+1].sat_quo[QBIT] = 1'b1;
         end
         if (div_ff[i].hue_rem >= hue_dvs) begin
            div_in[i+1].hue_rem       = div_ff[i].hue_rem - hue_dvs;
            div_in[i+1].hue_quo[QBIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[i+2]) begin
            div_ff[i+1] <= div_in[i+1];
         end
      end
   end

   // ---- output stage: apply sector base and wrap
   always_comb begin
      div_type d;
      hue_type q, base;
      d = div_ff[DIV_STAGES];
      q = HUE_BITS'(d.hue_quo[HUE_Q_BITS-1:0]);
      unique case (d.sector)
         SECT_RED:   base = HUE_BASE_RED;
         SECT_GREEN: base = HUE_BASE_GREEN;
         SECT_BLUE:  base = HUE_BASE_BLUE;
         default:    base = HUE_BASE_RED;
      endcase
      // grey or black: delta is zero, so the hue divisor was zero and the hue quotient is junk
      priority if (d.undef) begin
         hue_in = '0;
      end else if (d.neg && d.sector == SECT_RED) begin
         hue_in = HUE_FULL - q;
      end else if (d.neg) begin
         hue_in = base - q;
      end else begin
         hue_in = base + q;
      end
      sat_in = d.undef ? '0 : d.sat_quo[CHANNEL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ld[LAST]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= div_ff[DIV_STAGES].top;
         undef_ff <= div_ff[DIV_STAGES].undef;
      end
   end

   assign req_chan.ready          = ld[0];
   assign rsp_chan.valid          = vld_ff[LAST];
   assign rsp_chan.hue_out        = hue_ff;
   assign rsp_chan.saturation_out = sat_ff;
   assign rsp_chan.value_out      = value_ff;
   assign rsp_chan.hue_undefined  = undef_ff;

endmodule
`default_nettype wire

/* rtl/core/rhsv_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks on the converter's response channel.
// ----------------------------------------------------------------------------
module rhsv_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [rhsv_pkg::HUE_BITS-1:0]     rsp_hue_out,
   input wire [rhsv_pkg::CHANNEL_BITS-1:0] rsp_saturation_out,
   input wire [rhsv_pkg::CHANNEL_BITS-1:0] rsp_value_out,
   input wire                   rsp_hue_undefined
);
   import rhsv_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue_out)
         && $stable(rsp_saturation_out) && $stable(rsp_value_out)
         && $stable(rsp_hue_undefined))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_out < HUE_FULL)
      else $error("hue past full circle");

   // grey pixels carry no hue and no saturation
   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hue_undefined |-> rsp_hue_out == '0
         && rsp_saturation_out == '0)
      else $error("grey pixel with hue or saturation");

   // a colored pixel has nonzero value and saturation
   a_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hue_undefined |-> rsp_value_out != '0
         && rsp_saturation_out != '0)
      else $error("colored pixel with zero value or saturation");

endmodule

bind rgb_to_hsv_pixel_converter_top rhsv_checker u_rhsv_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_hue_out        (rsp_chan.hue_out),
   .rsp_saturation_out (rsp_chan.saturation_out),
   .rsp_value_out      (rsp_chan.value_out),
   .rsp_hue_undefined  (rsp_chan.hue_undefined)
);
`default_nettype wire
